@@ src/maag_pkg.sv @@
`timescale 1ns / 1ps
// package for the multidimensional array address generator
// holds word layouts, item kinds, descriptor types and the sequencer state type
// no dependencies
package maag_pkg;

   // word widths on the stream ports
   localparam int REQ_TDATA_W = 168;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   // field widths
   localparam int ID_W   = 4;
   localparam int DIM_W  = 4;
   localparam int ADDR_W = 31;
   localparam int WORD_W = 32;

   // request word layout, lowest bit first
   localparam int ID_LSB    = 0;
   localparam int DIM_LSB   = 4;
   localparam int BASE_LSB  = 8;
   localparam int SIZE_LSB  = 39;
   localparam int LOWER_LSB = 70;
   localparam int UPPER_LSB = 102;
   localparam int INDEX_LSB = 134;

   // item kinds carried on req_tuser
   localparam logic [REQ_TUSER_W-1:0] MODE_HEADER = 2'd0;
   localparam logic [REQ_TUSER_W-1:0] MODE_BOUNDS = 2'd1;
   localparam logic [REQ_TUSER_W-1:0] MODE_INDEX  = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0]  dims;
      logic [ADDR_W-1:0] esize;
      logic [ADDR_W-1:0] base;
   } hdr_type;

   typedef struct packed {
      logic [WORD_W-1:0] upper;
      logic [WORD_W-1:0] lower;
   } bnd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_MUL,
      ST_ADD
   } state_type;

endpackage

@@ src/multidim_array_address_generator.sv @@
`timescale 1ns / 1ps
// row-major multidimensional array address generator, top level
// depends on maag_pkg
//
// usage
// - req channel takes one word per item; req_tuser selects header write,
//   bounds write or one reference index; the other fields sit in req_tdata
// - a reference is a run of index words, one per dimension in order; the
//   first names the array, and after the last one a word with the address
//   and the array id leaves on the rsp channel
// - header and bounds words are written into the descriptor memories as they
//   are taken; an index word that is not the last passes the descriptor memory
//   read and the offset multiply-accumulate, the last one also the element
//   size multiply and the base add into the output register (a
//   zero-dimensional reference skips the multiply-accumulate), each with a register
// - the block works on one index word at a time; req_tready is low while it
//   is at work
// - the result sits in an output register, so the next items are taken
//   while rsp waits; a finished address waits in the last step until the
//   output register is free
// - synchronous reset closes any open reference and empties the output
//   register; descriptor memories are not cleared and must be written
//   before use
module multidim_array_address_generator #(
   parameter int NUM_ARRAYS = 16,
   parameter int MAX_DIMS   = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: array_id, dim, base_address, element_size, lower_bound,
   // upper_bound, index_value, 2 zero bits
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [maag_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: mode
   input  logic [maag_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // rsp_tdata: address, ref_array, 4 zero bits
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [maag_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import maag_pkg::*;

   localparam int HAW = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int BDEPTH = NUM_ARRAYS * MAX_DIMS;
   localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

   // request fields
   logic [ID_W-1:0]   req_id;
   logic [DIM_W-1:0]  req_dim;
   logic [WORD_W-1:0] req_index;
   hdr_type           req_hdr;
   bnd_type           req_bnd;

   assign req_id    = req_tdata[ID_LSB +: ID_W];
   assign req_dim   = req_tdata[DIM_LSB +: DIM_W];
   assign req_index = req_tdata[INDEX_LSB +: WORD_W];
   assign req_hdr.base  = req_tdata[BASE_LSB +: ADDR_W];
   assign req_hdr.esize = req_tdata[SIZE_LSB +: ADDR_W];
   // dimension count saturates at the largest supported rank
   assign req_hdr.dims  = (32'(req_dim) > MAX_DIMS) ? DIM_W'(MAX_DIMS) : req_dim;
   assign req_bnd.lower = req_tdata[LOWER_LSB +: WORD_W];
   assign req_bnd.upper = req_tdata[UPPER_LSB +: WORD_W];

   // descriptor memories
   hdr_type hdr_mem [NUM_ARRAYS];
   bnd_type bnd_mem [BDEPTH];
   hdr_type hdr_rd_ff;
   bnd_type bnd_rd_ff;

   // sequencer and datapath registers
   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  dim_pos_ff, dim_pos_in;
   logic [ID_W-1:0]   open_id_ff, open_id_in;
   logic [ID_W-1:0]   item_id_ff, item_id_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic              opening_ff, opening_in;
   logic              skip_ff, skip_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] span_ff, span_in;
   logic [WORD_W-1:0] diff_ff, diff_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;

   // accept-side decode
   logic           accept;
   logic           id_ok;
   logic           opening;
   logic           hdr_we;
   logic           bnd_we;
   logic           rd_en;
   logic [HAW-1:0] hdr_waddr;
   logic [BAW-1:0] bnd_waddr;
   logic [HAW-1:0] hdr_raddr;
   logic [BAW-1:0] bnd_raddr;
   logic [DIM_W:0] next_pos;
   logic           out_free;
   logic           load_rsp;

   assign accept  = req_tvalid && req_tready;
   assign id_ok   = 32'(req_id) < NUM_ARRAYS;
   assign opening = (dim_pos_ff == '0);

   assign hdr_we = accept && (req_tuser == MODE_HEADER) && id_ok;
   // dimension number 1..MAX_DIMS only
   assign bnd_we = accept && (req_tuser == MODE_BOUNDS) && id_ok && (req_dim != '0)
                   && (32'(req_dim) <= MAX_DIMS);
   // opening a reference needs a valid array id; later index words do not
   assign rd_en  = accept && (req_tuser == MODE_INDEX) && (!opening || id_ok);

   assign hdr_waddr = HAW'(req_id);
   assign bnd_waddr = BAW'(32'(req_id) * MAX_DIMS + 32'(req_dim) - 1);
   assign hdr_raddr = opening ? HAW'(req_id) : HAW'(open_id_ff);
   assign bnd_raddr = BAW'(32'(hdr_raddr) * MAX_DIMS + 32'(dim_pos_ff));

   // the sequencer keeps accesses apart: each item writes or reads in its accept
   // cycle only, so no entry is written and read in the same cycle
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[hdr_waddr] <= req_hdr;
      end
      if (rd_en) begin
         hdr_rd_ff <= hdr_mem[hdr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[bnd_waddr] <= req_bnd;
      end
      if (rd_en) begin
         bnd_rd_ff <= bnd_mem[bnd_raddr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == MODE_INDEX)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (skip_ff) begin
               state_in = ST_IDLE;
            end else if (opening_ff && (hdr_rd_ff.dims == '0)) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            state_in = done_ff ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !reset;
         ST_ADD:  load_rsp   = out_free;
         default: begin
            req_tready = 1'b0;
            load_rsp   = 1'b0;
         end
      endcase
   end

   // datapath
   assign next_pos = {1'b0, dim_pos_ff} + 1'b1;

   always_comb begin
      dim_pos_in   = dim_pos_ff;
      open_id_in   = open_id_ff;
      item_id_in   = item_id_ff;
      out_id_in    = out_id_ff;
      opening_in   = opening_ff;
      skip_in      = skip_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      span_in      = span_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_id_in = req_id;
               opening_in = opening;
               skip_in    = !rd_en;
               idx_in     = req_index;
            end
         end
         ST_READ: begin
            span_in = bnd_rd_ff.upper - bnd_rd_ff.lower + 1'b1;
            diff_in = idx_ff - bnd_rd_ff.lower;
            // last index once the count reaches the current rank
            done_in = (next_pos >= {1'b0, hdr_rd_ff.dims}) || (32'(next_pos) >= MAX_DIMS);
            if (opening_ff) begin
               open_id_in = item_id_ff;
               acc_in     = '0;
               out_id_in  = item_id_ff;
            end
         end
         ST_MAC: begin
            acc_in = acc_ff * span_ff + diff_ff;
            if (done_ff) begin
               dim_pos_in = '0;
               out_id_in  = open_id_ff;
            end else begin
               dim_pos_in = next_pos[DIM_W-1:0];
            end
         end
         ST_MUL: begin
            prod_in = {1'b0, hdr_rd_ff.esize} * acc_ff;
         end
         ST_ADD: begin
            if (load_rsp) begin
               rsp_addr_in  = {1'b0, hdr_rd_ff.base} + prod_ff;
               rsp_id_in    = out_id_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            dim_pos_in = dim_pos_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dim_pos_ff   <= '0;
         open_id_ff   <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_pos_ff   <= dim_pos_in;
         open_id_ff   <= open_id_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_id_ff  <= item_id_in;
      out_id_ff   <= out_id_in;
      opening_ff  <= opening_in;
      skip_ff     <= skip_in;
      done_ff     <= done_in;
      idx_ff      <= idx_in;
      span_ff     <= span_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_id_ff   <= rsp_id_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - WORD_W - ID_W)'(0), rsp_id_ff, rsp_addr_ff};

endmodule

@@ src/maag_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the multidimensional array address generator
// depends on maag_pkg; bound to multidim_array_address_generator below
module maag_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [maag_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [maag_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import maag_pkg::*;

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word present after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // an index word keeps the block busy for the next cycle
   a_index_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_INDEX) |=> !req_tready)
      else $error("req taken right after an index word");

   // a new result is only loaded from the final step, when req is held off
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("rsp word appeared while the block was idle");

endmodule

bind multidim_array_address_generator maag_checker u_maag_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/multidim_array_address_generator_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the multidimensional array address generator
// sends descriptor writes and index references, predicts each address and checks rsp words
// depends on maag_pkg and multidim_array_address_generator
module multidim_array_address_generator_tb;
   import maag_pkg::*;

   localparam int NUM_ARRAYS = 16;
   localparam int MAX_DIMS = 10;
   // item kind that the block drops
   localparam logic [REQ_TUSER_W-1:0] MODE_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   // an address reaches the output register through the read, multiply-accumulate,
   // multiply and add steps after its last index word, leave margin for stray words
   localparam int SETTLE_CYCLES = 20;
   // rsp word layout
   localparam int RSP_ADDR_LSB = 0;
   localparam int RSP_ID_LSB = 32;

   typedef struct {
      logic [REQ_TUSER_W-1:0] mode;
      logic [ID_W-1:0]        id;
      logic [DIM_W-1:0]       dim;
      logic [ADDR_W-1:0]      base;
      logic [ADDR_W-1:0]      esize;
      logic [WORD_W-1:0]      lower;
      logic [WORD_W-1:0]      upper;
      logic [WORD_W-1:0]      idx_val;
   } req_word_type;

   typedef struct {
      logic [WORD_W-1:0] address;
      logic [ID_W-1:0]   array_id;
   } addr_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // descriptor table as the block should hold it
   logic [WORD_W-1:0] base_m [NUM_ARRAYS];
   logic [WORD_W-1:0] size_m [NUM_ARRAYS];
   logic [DIM_W-1:0]  dims_m [NUM_ARRAYS];
   logic [WORD_W-1:0] lower_m [NUM_ARRAYS*MAX_DIMS];
   logic [WORD_W-1:0] upper_m [NUM_ARRAYS*MAX_DIMS];
   // which entries were written, so that stimulus never reads an empty one
   bit                hdr_ok [NUM_ARRAYS];
   bit                bnd_ok [NUM_ARRAYS*MAX_DIMS];
   // open reference
   logic [WORD_W-1:0] offset_m = '0;
   int                pos_m = 0;
   int                open_m = 0;

   addr_word_type expected_addrs [$];

   int fail_count = 0;
   int useful_words = 0;
   int addresses_checked = 0;
   int zero_dim_refs = 0;
   int stall_cycles = 0;
   bit throttle_off = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multidim_array_address_generator #(
      .NUM_ARRAYS(NUM_ARRAYS),
      .MAX_DIMS  (MAX_DIMS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // update the descriptor table and the open reference for one accepted word,
   // queue the address that the word completes, if any
   function automatic void predict_address(input req_word_type w);
      int slot;
      logic [WORD_W-1:0] span;
      addr_word_type r;
      case (w.mode)
         MODE_HEADER: begin
            base_m[w.id] = {1'b0, w.base};
            size_m[w.id] = {1'b0, w.esize};
            // counts above the table depth saturate
            dims_m[w.id] = (w.dim > MAX_DIMS) ? DIM_W'(MAX_DIMS) : w.dim;
            hdr_ok[w.id] = 1'b1;
            useful_words++;
         end
         MODE_BOUNDS: begin
            // dimension numbers are 1-based, anything else is dropped
            if (w.dim != 0 && w.dim <= MAX_DIMS) begin
               slot = w.id * MAX_DIMS + w.dim - 1;
               lower_m[slot] = w.lower;
               upper_m[slot] = w.upper;
               bnd_ok[slot] = 1'b1;
               useful_words++;
            end
         end
         MODE_INDEX: begin
            useful_words++;
            if (pos_m == 0) begin
               // first index names the array
               open_m = w.id;
               offset_m = '0;
               if (dims_m[w.id] == 0) begin
                  // zero-dimensional array: base address right away
                  r.address = base_m[w.id];
                  r.array_id = w.id;
                  expected_addrs.push_back(r);
                  zero_dim_refs++;
                  return;
               end
            end
            if (pos_m < MAX_DIMS) begin
               // horner step, everything wraps at 32 bits
               slot = open_m * MAX_DIMS + pos_m;
               span = upper_m[slot] - lower_m[slot] + 32'd1;
               offset_m = offset_m * span + (w.idx_val - lower_m[slot]);
            end
            pos_m++;
            // compare with the current count, a header rewrite may have cut it
            if (pos_m >= dims_m[open_m] || pos_m >= MAX_DIMS) begin
               pos_m = 0;
               r.address = base_m[open_m] + size_m[open_m] * offset_m;
               r.array_id = ID_W'(open_m);
               expected_addrs.push_back(r);
               offset_m = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_word_type random_word(input logic [REQ_TUSER_W-1:0] mode);
      req_word_type w;
      w.mode = mode;
      w.id = ID_W'($urandom);
      w.dim = DIM_W'($urandom);
      w.base = ADDR_W'($urandom);
      w.esize = ADDR_W'($urandom);
      w.lower = $urandom;
      w.upper = $urandom;
      w.idx_val = $urandom;
      return w;
   endfunction

   function automatic req_word_type build_word(input logic [REQ_TUSER_W-1:0] mode,
                                               input logic [ID_W-1:0] id,
                                               input logic [DIM_W-1:0] dim,
                                               input logic [ADDR_W-1:0] base,
                                               input logic [ADDR_W-1:0] esize,
                                               input logic [WORD_W-1:0] lower,
                                               input logic [WORD_W-1:0] upper,
                                               input logic [WORD_W-1:0] idx_val);
      req_word_type w;
      w.mode = mode;
      w.id = id;
      w.dim = dim;
      w.base = base;
      w.esize = esize;
      w.lower = lower;
      w.upper = upper;
      w.idx_val = idx_val;
      return w;
   endfunction

   // mostly in range, now and then the bounds themselves or anything at all
   function automatic logic [WORD_W-1:0] pick_index(input int slot);
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] span;
      lo = lower_m[slot];
      hi = upper_m[slot];
      span = hi - lo;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return lo;
         2: return hi;
         default: begin
            if ($signed(hi) >= $signed(lo) && span < 32'd4096)
               return lo + $urandom_range(0, span);
            return $urandom;
         end
      endcase
   endfunction

   // one word on req, with an occasional idle burst in front
   task automatic send_word(input req_word_type w);
      if (!throttle_off && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tdata <= {2'b00, w.idx_val, w.upper, w.lower, w.esize, w.base, w.dim, w.id};
      req_tuser <= w.mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_address(w);
   endtask

   task automatic send_header(input logic [ID_W-1:0] id);
      req_word_type w;
      w = random_word(MODE_HEADER);
      w.id = id;
      if ($urandom_range(0, 3) != 0) w.esize = ADDR_W'($urandom_range(0, 16));
      case ($urandom_range(0, 7))
         0: w.dim = '0;
         1: w.dim = DIM_W'($urandom_range(5, 15));
         default: w.dim = DIM_W'($urandom_range(1, 4));
      endcase
      send_word(w);
   endtask

   task automatic send_bounds(input logic [ID_W-1:0] id, input int d);
      req_word_type w;
      w = random_word(MODE_BOUNDS);
      w.id = id;
      w.dim = DIM_W'(d);
      // narrow ranges near zero most of the time, full random otherwise
      if ($urandom_range(0, 3) != 0) begin
         w.lower = WORD_W'($urandom_range(0, 2000)) - 32'd1000;
         w.upper = w.lower + WORD_W'($urandom_range(0, 15));
      end
      send_word(w);
   endtask

   // next index word of a reference; writes missing descriptor parts first
   task automatic step_reference(input logic [ID_W-1:0] id);
      req_word_type w;
      int slot;
      if (pos_m == 0) begin
         if (!hdr_ok[id]) send_header(id);
         if (!bnd_ok[id * MAX_DIMS]) send_bounds(id, 1);
         slot = id * MAX_DIMS;
      end else begin
         slot = open_m * MAX_DIMS + pos_m;
         if (!bnd_ok[slot]) send_bounds(ID_W'(open_m), pos_m + 1);
      end
      w = random_word(MODE_INDEX);
      // later words of a reference carry a random id, which must be ignored
      if (pos_m == 0) w.id = id;
      w.idx_val = pick_index(slot);
      send_word(w);
   endtask

   task automatic run_reference(input logic [ID_W-1:0] id);
      do
         step_reference(id);
      while (pos_m != 0);
   endtask

   task automatic test_directed_cases();
      // zero-dimensional array, index ignored, largest element size
      send_word(build_word(MODE_HEADER, 4'd0, 4'd0, 31'd0, 31'h7fffffff, '0, '0, '0));
      send_word(build_word(MODE_BOUNDS, 4'd0, 4'd1, '0, '0, 32'h80000000, 32'h7fffffff, '0));
      send_word(build_word(MODE_INDEX, 4'd0, 4'd0, '0, '0, '0, '0, 32'hffffffff));
      // extreme base, size and bounds, reversed bounds on the first dimension
      send_word(build_word(MODE_HEADER, 4'd15, 4'd2, 31'h7fffffff, 31'h7fffffff, '0, '0, '0));
      send_word(build_word(MODE_BOUNDS, 4'd15, 4'd1, '0, '0, 32'h7fffffff, 32'h80000000, '0));
      send_word(build_word(MODE_BOUNDS, 4'd15, 4'd2, '0, '0, 32'h80000000, 32'h7fffffff, '0));
      // dimension numbers outside 1..MAX_DIMS are dropped
      send_word(build_word(MODE_BOUNDS, 4'd15, 4'd0, '0, '0, '1, '1, '0));
      send_word(build_word(MODE_BOUNDS, 4'd15, 4'd11, '0, '0, '1, '1, '0));
      send_word(build_word(MODE_BOUNDS, 4'd15, 4'd15, '0, '0, '1, '1, '0));
      // spare item kind, all fields high
      send_word(build_word(MODE_SPARE, '1, '1, '1, '1, '1, '1, '1));
      // second word of the reference carries a foreign id
      send_word(build_word(MODE_INDEX, 4'd15, '1, '1, '1, '1, '1, 32'h80000000));
      send_word(build_word(MODE_INDEX, 4'd9, '0, '0, '0, '0, '0, 32'h7fffffff));
      // count above the table depth saturates
      send_word(build_word(MODE_HEADER, 4'd1, 4'd15, 31'd1000, 31'd4, '0, '0, '0));
      send_word(build_word(MODE_BOUNDS, 4'd1, 4'd1, '0, '0, 32'd0, 32'd9, '0));
      send_word(build_word(MODE_BOUNDS, 4'd1, 4'd2, '0, '0, -32'sd5, 32'd5, '0));
      send_word(build_word(MODE_BOUNDS, 4'd1, 4'd3, '0, '0, 32'd100, 32'd103, '0));
      send_word(build_word(MODE_INDEX, 4'd1, '0, '0, '0, '0, '0, 32'd3));
      send_word(build_word(MODE_INDEX, 4'd15, '0, '0, '0, '0, '0, 32'd5));
      // header rewritten mid-reference: count drops to 2, next word closes it
      send_word(build_word(MODE_HEADER, 4'd1, 4'd2, 31'd2000, 31'd8, '0, '0, '0));
      send_word(build_word(MODE_INDEX, 4'd0, '0, '0, '0, '0, '0, 32'd101));
      // index far outside its bounds
      send_word(build_word(MODE_INDEX, 4'd1, '0, '0, '0, '0, '0, 32'hffffffff));
      send_word(build_word(MODE_INDEX, 4'd1, '0, '0, '0, '0, '0, 32'd0));
      // zero element size
      send_word(build_word(MODE_HEADER, 4'd2, 4'd1, 31'h7fffffff, 31'd0, '0, '0, '0));
      send_word(build_word(MODE_BOUNDS, 4'd2, 4'd1, '0, '0, 32'd0, 32'd0, '0));
      send_word(build_word(MODE_INDEX, 4'd2, '0, '0, '0, '0, '0, 32'd12345));
   endtask

   task automatic test_well_formed_references(input int target);
      logic [ID_W-1:0] id;
      while (useful_words < target) begin
         id = ID_W'($urandom);
         case ($urandom_range(0, 9))
            0: send_header(id);
            1: send_bounds(id, $urandom_range(1, MAX_DIMS));
            default: run_reference(id);
         endcase
      end
   endtask

   // references interleaved with header rewrites, stray bounds and spare items
   task automatic test_broken_sequences(input int target);
      while (useful_words < target) begin
         case ($urandom_range(0, 9))
            0: send_header(ID_W'($urandom));
            1: send_word(random_word(MODE_BOUNDS));
            2: send_word(random_word(MODE_SPARE));
            3: send_header(pos_m != 0 ? ID_W'(open_m) : ID_W'($urandom));
            default: step_reference(ID_W'($urandom));
         endcase
      end
   endtask

   task automatic test_unthrottled_references(input int target);
      throttle_off = 1'b1;
      while (useful_words < target || pos_m != 0)
         run_reference(ID_W'($urandom));
   endtask

   // rsp side back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!throttle_off && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // compare each address word with the oldest prediction
   always @(posedge clock) begin
      addr_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_addrs.size() == 0) begin
            $display("%0t: address word expected none actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_addrs.pop_front();
            if (rsp_tdata[RSP_ADDR_LSB +: WORD_W] !== want.address) begin
               $display("%0t: address expected %h actual %h", $time, want.address,
                        rsp_tdata[RSP_ADDR_LSB +: WORD_W]);
               fail_count++;
            end
            if (rsp_tdata[RSP_ID_LSB +: ID_W] !== want.array_id) begin
               $display("%0t: ref_array expected %0d actual %0d", $time, want.array_id,
                        rsp_tdata[RSP_ID_LSB +: ID_W]);
               fail_count++;
            end
            addresses_checked++;
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_well_formed_references(900);
      test_broken_sequences(1350);
      test_unthrottled_references(1550);
      req_tvalid <= 1'b0;
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d descriptor and index words, %0d addresses checked", useful_words,
               addresses_checked);
      $display("including %0d zero-dimension references, with and without idle bursts",
               zero_dim_refs);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/maag_pkg.sv
src/multidim_array_address_generator.sv
src/maag_checker.sv
dv/multidim_array_address_generator_tb.sv
